### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the sector chain allocator.
// Each use expands to one labelled concurrent assertion that is switched off
// while the synchronous reset is held.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define SCA_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the usual i_clk and i_rst_n of a module.
`define SCA_ASSERT(label, prop, msg) \
    `SCA_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

### design/sca_pkg.sv
// ---------------------------------------------------------------------------
// sca_pkg: shared types and constants of the sector chain allocator
// Table sizes, entry codes, request modes and the command and status
// bundles that join the sequencer to the datapath.
// ---------------------------------------------------------------------------
package sca_pkg;

    localparam int MAX_SECTORS = 4096;
    localparam int IDX_W       = 12;
    localparam int CNT_W       = 13;
    localparam int ENT_W       = 13;

    // An entry holds a link (below MAX_SECTORS), a free mark or an end mark.
    localparam logic [ENT_W-1:0] ENTRY_FREE = 13'h1FFE;
    localparam logic [ENT_W-1:0] ENTRY_EOC  = 13'h1FFF;

    localparam logic [CNT_W-1:0] FREE_CAP    = 13'h1FFF;
    localparam logic [CNT_W-1:0] SECTORS_MAX = 13'(MAX_SECTORS);
    localparam logic [CNT_W-1:0] FREE_RST    = 13'(MAX_SECTORS - 1);
    localparam logic [CNT_W-1:0] CLR_LAST    = 13'(MAX_SECTORS - 1);

    typedef enum logic [2:0] {
        MODE_ALLOC   = 3'd0,
        MODE_APPEND  = 3'd1,
        MODE_RELEASE = 3'd2,
        MODE_TRUNC   = 3'd3,
        MODE_READ    = 3'd4,
        MODE_FORMAT  = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_IDX  = 2'd1,
        RD_CUR  = 2'd2
    } t_rd_op;

    typedef enum logic [2:0] {
        WR_NONE     = 3'd0,
        WR_CLEAR    = 3'd1,
        WR_ALLOC    = 3'd2,
        WR_LINK     = 3'd3,
        WR_LINK_END = 3'd4,
        WR_CUT      = 3'd5,
        WR_FREE     = 3'd6
    } t_wr_op;

    typedef struct packed {
        logic   load;
        t_rd_op rd_op;
        t_wr_op wr_op;
        logic   clr_init;
        logic   scan_init;
        logic   scan_wrap;
        logic   scan_next;
        logic   set_full;
        logic   walk_init;
        logic   walk_trunc;
        logic   walk_step;
        logic   rel_init;
        logic   rdn_cap;
        logic   emit;
    } t_sca_cmd;

    typedef struct packed {
        logic free_zero;
        logic scan_ok;
        logic scan_phase;
        logic clr_last;
        logic rd_free;
        logic rd_eoc;
        logic rd_link;
        logic walk_more;
        logic rel_skip;
        logic out_free;
    } t_sca_stat;

endpackage

### design/sca_dpath.sv
// ---------------------------------------------------------------------------
// sca_dpath: table memory, counters and result register
// Holds the linked sector table, the free count, the search hint, the walk
// and scan counters and the output register, all driven by sequencer commands.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sca_dpath
    import sca_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_sca_cmd         i_cmd,
    output t_sca_stat        o_stat,
    input  logic [IDX_W-1:0] i_start_index,
    input  logic [IDX_W-1:0] i_link_index,
    input  logic [CNT_W-1:0] i_keep_length,
    input  logic             i_cfg_valid,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output logic [IDX_W-1:0] o_result_index,
    output logic             o_at_end,
    output logic             o_status,
    output logic [CNT_W-1:0] o_free_left
);

    logic [ENT_W-1:0] r_mem [MAX_SECTORS];
    logic [ENT_W-1:0] r_rdata;

    logic [CNT_W-1:0] r_sector_count;
    logic [CNT_W-1:0] r_idx;
    logic             r_phase;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_lim;
    logic             r_first;
    logic [CNT_W-1:0] r_free;
    logic [CNT_W-1:0] r_hint;
    logic             r_out_vld;

    logic [IDX_W-1:0] r_cur;
    logic [IDX_W-1:0] r_link;
    logic [IDX_W-1:0] r_res;
    logic             r_at_end;
    logic             r_status;
    logic [IDX_W-1:0] r_out_res;
    logic             r_out_at_end;
    logic             r_out_status;
    logic [CNT_W-1:0] r_out_free;

    logic [CNT_W-1:0] w_bound;
    logic [CNT_W-1:0] w_lim;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_we;
    logic [IDX_W-1:0] w_wr_addr;
    logic [ENT_W-1:0] w_wr_data;
    logic             w_rd_link;
    logic             w_rd_free;

    assign w_bound = (r_sector_count < SECTORS_MAX) ? r_sector_count : SECTORS_MAX;
    assign w_lim   = (r_hint < w_bound) ? r_hint : w_bound;

    assign w_rd_link = (r_rdata < SECTORS_MAX);
    assign w_rd_free = (r_rdata == ENTRY_FREE);

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_cur;
        unique case (i_cmd.rd_op)
            RD_IDX: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_idx[IDX_W-1:0];
            end
            RD_CUR: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_cur;
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_we      = 1'b1;
        w_wr_addr = r_cur;
        w_wr_data = ENTRY_EOC;
        unique case (i_cmd.wr_op)
            WR_CLEAR: begin
                w_wr_addr = r_idx[IDX_W-1:0];
                w_wr_data = (r_idx == '0) ? ENTRY_EOC : ENTRY_FREE;
            end
            WR_ALLOC: begin
                w_wr_addr = r_idx[IDX_W-1:0];
            end
            WR_LINK: begin
                w_wr_data = {1'b0, r_link};
            end
            WR_LINK_END: begin
                w_wr_addr = r_link;
            end
            WR_CUT: begin
                w_wr_data = ENTRY_EOC;
            end
            WR_FREE: begin
                w_wr_data = ENTRY_FREE;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Table memory: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // Control state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_count <= SECTORS_MAX;
            r_idx          <= '0;
            r_phase        <= 1'b0;
            r_cnt          <= '0;
            r_lim          <= '0;
            r_first        <= 1'b0;
            r_free         <= FREE_RST;
            r_hint         <= 13'd1;
            r_out_vld      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_sector_count <= i_cfg_data;
            end
            if (i_cmd.clr_init) begin
                r_idx  <= '0;
                r_free <= (w_bound != '0) ? w_bound - 13'd1 : '0;
                r_hint <= 13'd1;
            end
            if (i_cmd.wr_op == WR_CLEAR || i_cmd.scan_next) begin
                r_idx <= r_idx + 13'd1;
            end
            if (i_cmd.scan_init) begin
                r_idx   <= r_hint;
                r_phase <= 1'b0;
            end
            if (i_cmd.scan_wrap) begin
                r_idx   <= '0;
                r_phase <= 1'b1;
            end
            if (i_cmd.wr_op == WR_ALLOC) begin
                r_hint <= r_idx + 13'd1;
                r_free <= r_free - 13'd1;
            end
            if (i_cmd.walk_init) begin
                r_cnt <= i_cmd.walk_trunc ? 13'd1 : 13'd0;
                r_lim <= i_cmd.walk_trunc ? i_keep_length : SECTORS_MAX;
            end
            if (i_cmd.walk_step) begin
                r_cnt <= r_cnt + 13'd1;
            end
            if (i_cmd.rel_init) begin
                r_cnt   <= '0;
                r_lim   <= SECTORS_MAX;
                r_first <= 1'b1;
            end
            if (i_cmd.wr_op == WR_FREE) begin
                r_cnt   <= r_cnt + 13'd1;
                r_first <= 1'b0;
                if (r_free != FREE_CAP) begin
                    r_free <= r_free + 13'd1;
                end
                if ({1'b0, r_cur} < r_hint) begin
                    r_hint <= {1'b0, r_cur};
                end
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Operands, results and the output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur    <= i_start_index;
            r_link   <= i_link_index;
            r_res    <= '0;
            r_at_end <= 1'b0;
            r_status <= 1'b0;
        end
        if (i_cmd.walk_step || i_cmd.wr_op == WR_CUT || i_cmd.wr_op == WR_FREE) begin
            r_cur <= r_rdata[IDX_W-1:0];
        end
        if (i_cmd.wr_op == WR_ALLOC) begin
            r_res <= r_idx[IDX_W-1:0];
        end
        if (i_cmd.set_full) begin
            r_status <= 1'b1;
        end
        if (i_cmd.rdn_cap) begin
            r_at_end <= (r_rdata == ENTRY_EOC);
            r_res    <= w_rd_link ? r_rdata[IDX_W-1:0] : '0;
        end
        if (i_cmd.emit) begin
            r_out_res    <= r_res;
            r_out_at_end <= r_at_end;
            r_out_status <= r_status;
            r_out_free   <= r_free;
        end
    end

    always_comb begin
        o_stat.free_zero  = (r_free == '0);
        o_stat.scan_ok    = r_phase ? (r_idx < w_lim) : (r_idx < w_bound);
        o_stat.scan_phase = r_phase;
        o_stat.clr_last   = (r_idx == CLR_LAST);
        o_stat.rd_free    = w_rd_free;
        o_stat.rd_eoc     = (r_rdata == ENTRY_EOC);
        o_stat.rd_link    = w_rd_link;
        o_stat.walk_more  = (r_cnt < r_lim);
        o_stat.rel_skip   = r_first && (r_cur == '0 || w_rd_free);
        o_stat.out_free   = !r_out_vld || i_m_tready;
    end

    assign o_m_tvalid     = r_out_vld;
    assign o_result_index = r_out_res;
    assign o_at_end       = r_out_at_end;
    assign o_status       = r_out_status;
    assign o_free_left    = r_out_free;

    `SCA_ASSERT(a_hint_range, r_hint <= SECTORS_MAX, "free hint points beyond the table")
    `SCA_ASSERT(a_alloc_count, (i_cmd.wr_op == WR_ALLOC) |=> (r_free == $past(r_free) - 13'd1), "allocation did not take one from the free count")
    `SCA_ASSERT(a_release_count, (i_cmd.wr_op == WR_FREE && r_free != FREE_CAP) |=> (r_free == $past(r_free) + 13'd1), "released entry not added to the free count")

endmodule

### design/sca_ctrl.sv
// ---------------------------------------------------------------------------
// sca_ctrl: request sequencer of the sector chain allocator
// One-hot state machine that steps the datapath through the clearing sweep,
// the free search, the chain walks and the result hand-off.
// ---------------------------------------------------------------------------
module sca_ctrl
    import sca_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_mode,
    output logic       o_in_ready,
    input  t_sca_stat  i_stat,
    output t_sca_cmd   o_cmd
);

    typedef enum logic [15:0] {
        S_INIT     = 16'h0001,
        S_IDLE     = 16'h0002,
        S_CLEAR    = 16'h0004,
        S_SCAN_RD  = 16'h0008,
        S_SCAN_EV  = 16'h0010,
        S_WALK_RD  = 16'h0020,
        S_WALK_EV  = 16'h0040,
        S_APP_LINK = 16'h0080,
        S_APP_END  = 16'h0100,
        S_TAIL_RD  = 16'h0200,
        S_TAIL_EV  = 16'h0400,
        S_REL_RD   = 16'h0800,
        S_REL_EV   = 16'h1000,
        S_RDN_RD   = 16'h2000,
        S_RDN_EV   = 16'h4000,
        S_DONE     = 16'h8000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_mode  r_mode;
    t_state w_walk_next;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_walk_next = (r_mode == MODE_APPEND) ? S_APP_LINK : S_TAIL_RD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_mode  <= MODE_ALLOC;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_in_valid) begin
                r_mode <= t_mode'(i_mode);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.wr_op = WR_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (t_mode'(i_mode))
                        MODE_ALLOC: begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN_RD;
                        end
                        MODE_APPEND: begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = S_WALK_RD;
                        end
                        MODE_RELEASE: begin
                            o_cmd.rel_init = 1'b1;
                            n_state        = S_REL_RD;
                        end
                        MODE_TRUNC: begin
                            o_cmd.walk_init  = 1'b1;
                            o_cmd.walk_trunc = 1'b1;
                            n_state          = S_WALK_RD;
                        end
                        MODE_READ: begin
                            n_state = S_RDN_RD;
                        end
                        MODE_FORMAT: begin
                            o_cmd.clr_init = 1'b1;
                            n_state        = S_CLEAR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.wr_op = WR_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN_RD: begin
                priority if (i_stat.free_zero) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_DONE;
                end else if (i_stat.scan_ok) begin
                    o_cmd.rd_op = RD_IDX;
                    n_state     = S_SCAN_EV;
                end else if (!i_stat.scan_phase) begin
                    o_cmd.scan_wrap = 1'b1;
                end else begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_SCAN_EV: begin
                if (i_stat.rd_free) begin
                    o_cmd.wr_op = WR_ALLOC;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_WALK_RD: begin
                if (i_stat.walk_more) begin
                    o_cmd.rd_op = RD_CUR;
                    n_state     = S_WALK_EV;
                end else begin
                    n_state = w_walk_next;
                end
            end
            S_WALK_EV: begin
                if (i_stat.rd_link) begin
                    o_cmd.walk_step = 1'b1;
                    n_state         = S_WALK_RD;
                end else begin
                    n_state = w_walk_next;
                end
            end
            S_APP_LINK: begin
                o_cmd.wr_op = WR_LINK;
                n_state     = S_APP_END;
            end
            S_APP_END: begin
                o_cmd.wr_op = WR_LINK_END;
                n_state     = S_DONE;
            end
            S_TAIL_RD: begin
                o_cmd.rd_op = RD_CUR;
                n_state     = S_TAIL_EV;
            end
            S_TAIL_EV: begin
                if (i_stat.rd_link) begin
                    o_cmd.wr_op    = WR_CUT;
                    o_cmd.rel_init = 1'b1;
                    n_state        = S_REL_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REL_RD: begin
                if (i_stat.walk_more) begin
                    o_cmd.rd_op = RD_CUR;
                    n_state     = S_REL_EV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REL_EV: begin
                if (i_stat.rel_skip) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.wr_op = WR_FREE;
                    n_state     = i_stat.rd_link ? S_REL_RD : S_DONE;
                end
            end
            S_RDN_RD: begin
                o_cmd.rd_op = RD_CUR;
                n_state     = S_RDN_EV;
            end
            S_RDN_EV: begin
                o_cmd.rdn_cap = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/sector_chain_allocator_top.sv
// ---------------------------------------------------------------------------
// sector_chain_allocator_top: linked sector table allocator
// Top level joining the request sequencer and the table datapath to the
// stream channels and the sector count register port.
// ---------------------------------------------------------------------------
// Usage. Requests arrive as beats on the slave stream: tuser carries the mode
// (allocate, append, release, truncate, read next, format) and tdata the start
// sector, the link sector and the keep length. Every request gives exactly one
// result beat on the master stream with the sector index, the end-of-chain and
// disk-full flags and the free count left after the request.
// The sector count register is written through its own valid/ready channel,
// which is always ready; it bounds the free search and the format count.
// Timing. One request is in work at a time; tready is high only when the
// sequencer is idle. Each table access is a read state and an evaluate state
// on the registered read port of the table memory, so a chain walk passes
// through both for every link, an allocate for every entry inspected, and
// read next makes a single access. Format writes one entry a cycle.
// Reset. After the synchronous reset the table is swept the same way, with
// tready low, leaving every entry free but sector zero.
// Stalls. The result sits in an output register; the next request is taken
// while it waits, and the sequencer holds its next result until that register
// is emptied.
// ---------------------------------------------------------------------------
module sector_chain_allocator_top
    import sca_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // start_index[11:0], link_index[23:12], keep_length[36:24]
    input  logic [2:0]  i_s_tuser,  // mode[2:0]
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // result_index[11:0], free_left[24:12]
    output logic [1:0]  o_m_tuser,  // at_end[0], status[1]
    // Sector count register write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data
);

    t_sca_cmd         w_cmd;
    t_sca_stat        w_stat;
    logic [IDX_W-1:0] w_result_index;
    logic             w_at_end;
    logic             w_status;
    logic [CNT_W-1:0] w_free_left;

    // The register port never back-pressures; each write goes straight into the sector count register.
    assign o_cfg_ready = 1'b1;

    sca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_mode     (i_s_tuser),
        .o_in_ready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sca_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_start_index  (i_s_tdata[11:0]),
        .i_link_index   (i_s_tdata[23:12]),
        .i_keep_length  (i_s_tdata[36:24]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_result_index (w_result_index),
        .o_at_end       (w_at_end),
        .o_status       (w_status),
        .o_free_left    (w_free_left)
    );

    // Result fields packed from the lowest bit up, padded to whole bytes.
    assign o_m_tdata = {7'd0, w_free_left, w_result_index};
    assign o_m_tuser = {w_status, w_at_end};

endmodule
